[hw/rtl/spc_pkg.sv]
// spc_pkg: shared types and constants of the sprite pixel collision block
// used by the controller, datapath and top level of the block and by its checker; no dependencies
`default_nettype none

package spc_pkg;

  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned PIX_W   = 6;
  localparam int unsigned CRD_W   = 18;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_CHECK  = 2'd2
  } action_e;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY      = 3'd4;

  localparam logic [SIZE_W-1:0]  SIZE_RST = 7'd16;
  localparam logic [COLOR_W-1:0] KEY_RST  = 16'd63519;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic capture;
    logic corner;
    logic bound;
    logic span;
    logic read;
    logic publish;
  } spc_cmd_t;

  typedef struct packed {
    logic empty;
    logic last_row;
  } spc_stat_t;

endpackage

`default_nettype wire

[hw/rtl/spc_item_if.sv]
// spc_item_if: input item channel (loads and checks) with valid/ready
// depends on nothing
`default_nettype none

interface spc_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [5:0]         pixel_x;
  logic [5:0]         pixel_y;
  logic [15:0]        pixel_color;
  logic signed [15:0] center_ax;
  logic signed [15:0] center_ay;
  logic signed [15:0] center_bx;
  logic signed [15:0] center_by;

  modport source (output valid, action, pixel_x, pixel_y, pixel_color,
                  center_ax, center_ay, center_bx, center_by, input ready);
  modport sink (input valid, action, pixel_x, pixel_y, pixel_color,
                center_ax, center_ay, center_bx, center_by, output ready);
endinterface

`default_nettype wire

[hw/rtl/spc_hit_if.sv]
// spc_hit_if: result channel carrying the collision flag with valid/ready
// depends on nothing
`default_nettype none

interface spc_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

[hw/rtl/spc_cfg_if.sv]
// spc_cfg_if: register write channel with valid/ready, index and data
// depends on nothing
`default_nettype none

interface spc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/spc_ctrl.sv]
// spc_ctrl: state machine sequencing loads, the check setup and the row scan
// depends on spc_pkg
`default_nettype none

module spc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 item_valid_i,
  input  wire logic [1:0]           action_i,
  output logic                      item_ready_o,
  input  wire logic                 hit_ready_i,
  output logic                      hit_valid_o,
  input  wire spc_pkg::spc_stat_t   stat_i,
  output spc_pkg::spc_cmd_t         cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CORNER = 3'd1;
  localparam logic [2:0] ST_BOUND  = 3'd2;
  localparam logic [2:0] ST_SPAN   = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       acc;
  logic       publish;

  assign item_ready_o = (state_q == ST_IDLE);
  assign acc          = item_valid_i && item_ready_o;
  assign publish      = (state_q == ST_FINISH) && (!out_valid_q || hit_ready_i);
  assign hit_valid_o  = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load_a  = acc && (action_i == spc_pkg::ACT_LOAD_A);
    cmd_o.load_b  = acc && (action_i == spc_pkg::ACT_LOAD_B);
    cmd_o.capture = acc && (action_i == spc_pkg::ACT_CHECK);
    cmd_o.corner  = (state_q == ST_CORNER);
    cmd_o.bound   = (state_q == ST_BOUND);
    cmd_o.span    = (state_q == ST_SPAN);
    cmd_o.read    = (state_q == ST_SCAN);
    cmd_o.publish = publish;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && (action_i == spc_pkg::ACT_CHECK)) state_d = ST_CORNER;
      end
      ST_CORNER: state_d = ST_BOUND;
      ST_BOUND:  state_d = ST_SPAN;
      ST_SPAN: begin
        state_d = stat_i.empty ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.last_row) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: begin
        if (publish) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && hit_ready_i) out_valid_d = 1'b0;
    if (publish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/spc_datapath.sv]
// spc_datapath: opaque masks, rectangle intersection and row-wise mask compare
// depends on spc_pkg
`default_nettype none

module spc_datapath #(
  parameter int unsigned MAX_DIM = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire spc_pkg::spc_cmd_t           cmd_i,
  output spc_pkg::spc_stat_t               stat_o,
  input  wire logic [spc_pkg::PIX_W-1:0]   pixel_x_i,
  input  wire logic [spc_pkg::PIX_W-1:0]   pixel_y_i,
  input  wire logic [spc_pkg::COLOR_W-1:0] pixel_color_i,
  input  wire logic signed [spc_pkg::COORD_W-1:0] center_ax_i,
  input  wire logic signed [spc_pkg::COORD_W-1:0] center_ay_i,
  input  wire logic signed [spc_pkg::COORD_W-1:0] center_bx_i,
  input  wire logic signed [spc_pkg::COORD_W-1:0] center_by_i,
  input  wire logic [spc_pkg::SIZE_W-1:0]  width_a_i,
  input  wire logic [spc_pkg::SIZE_W-1:0]  height_a_i,
  input  wire logic [spc_pkg::SIZE_W-1:0]  width_b_i,
  input  wire logic [spc_pkg::SIZE_W-1:0]  height_b_i,
  input  wire logic [spc_pkg::COLOR_W-1:0] key_i,
  output logic                             hit_o
);

  localparam int unsigned IdxW = $clog2(MAX_DIM);
  localparam int unsigned OwW  = $clog2(MAX_DIM + 1);
  localparam int unsigned CW   = spc_pkg::CRD_W;

  logic [MAX_DIM-1:0] mem_a_q [MAX_DIM];
  logic [MAX_DIM-1:0] mem_b_q [MAX_DIM];
  logic [MAX_DIM-1:0] rd_a_q, rd_b_q;

  logic signed [spc_pkg::COORD_W-1:0] cax_q, cay_q, cbx_q, cby_q;
  logic signed [CW-1:0] ax0_q, ax1_q, ay0_q, ay1_q;
  logic signed [CW-1:0] bx0_q, bx1_q, by0_q, by1_q;
  logic signed [CW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic signed [CW-1:0] sa_full, sb_full, ra_full, rb_full, ow_full, oh_full;
  logic [IdxW-1:0] sa_q, sb_q, ra_q, rb_q;
  logic [OwW-1:0]  ow_q, rows_q;
  logic [IdxW-1:0] wr_x, wr_y;
  logic            in_a, in_b, opaque;
  logic            eval_q, hit_acc_q, hit_q;
  logic [MAX_DIM-1:0] col_mask, overlap;

  // load path
  assign wr_x   = IdxW'(pixel_x_i);
  assign wr_y   = IdxW'(pixel_y_i);
  assign opaque = (pixel_color_i != key_i);
  assign in_a   = ({1'b0, pixel_x_i} < width_a_i) && ({1'b0, pixel_y_i} < height_a_i);
  assign in_b   = ({1'b0, pixel_x_i} < width_b_i) && ({1'b0, pixel_y_i} < height_b_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && in_a) mem_a_q[wr_y][wr_x] <= opaque;
    if (cmd_i.read) rd_a_q <= mem_a_q[ra_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_b && in_b) mem_b_q[wr_y][wr_x] <= opaque;
    if (cmd_i.read) rd_b_q <= mem_b_q[rb_q];
  end

  // check setup
  assign sa_full = x0_q - ax0_q;
  assign sb_full = x0_q - bx0_q;
  assign ra_full = y0_q - ay0_q;
  assign rb_full = y0_q - by0_q;
  assign ow_full = x1_q - x0_q;
  assign oh_full = y1_q - y0_q;

  assign stat_o.empty    = (x1_q <= x0_q) || (y1_q <= y0_q);
  assign stat_o.last_row = (rows_q == OwW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cax_q <= center_ax_i;
      cay_q <= center_ay_i;
      cbx_q <= center_bx_i;
      cby_q <= center_by_i;
    end
    if (cmd_i.corner) begin
      ax0_q <= CW'(cax_q) - $signed(CW'(width_a_i >> 1));
      ax1_q <= CW'(cax_q) + $signed(CW'(width_a_i - (width_a_i >> 1)));
      ay0_q <= CW'(cay_q) - $signed(CW'(height_a_i >> 1));
      ay1_q <= CW'(cay_q) + $signed(CW'(height_a_i - (height_a_i >> 1)));
      bx0_q <= CW'(cbx_q) - $signed(CW'(width_b_i >> 1));
      bx1_q <= CW'(cbx_q) + $signed(CW'(width_b_i - (width_b_i >> 1)));
      by0_q <= CW'(cby_q) - $signed(CW'(height_b_i >> 1));
      by1_q <= CW'(cby_q) + $signed(CW'(height_b_i - (height_b_i >> 1)));
    end
    if (cmd_i.bound) begin
      x0_q <= (ax0_q > bx0_q) ? ax0_q : bx0_q;
      y0_q <= (ay0_q > by0_q) ? ay0_q : by0_q;
      x1_q <= (ax1_q < bx1_q) ? ax1_q : bx1_q;
      y1_q <= (ay1_q < by1_q) ? ay1_q : by1_q;
    end
    if (cmd_i.span) begin
      sa_q   <= sa_full[IdxW-1:0];
      sb_q   <= sb_full[IdxW-1:0];
      ra_q   <= ra_full[IdxW-1:0];
      rb_q   <= rb_full[IdxW-1:0];
      ow_q   <= ow_full[OwW-1:0];
      rows_q <= oh_full[OwW-1:0];
    end else if (cmd_i.read) begin
      ra_q   <= ra_q + IdxW'(1);
      rb_q   <= rb_q + IdxW'(1);
      rows_q <= rows_q - OwW'(1);
    end
  end

  // row compare, one row pair per cycle
  assign col_mask = ~({MAX_DIM{1'b1}} << ow_q);
  assign overlap  = (rd_a_q >> sa_q) & (rd_b_q >> sb_q) & col_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q <= 1'b0;
    end else begin
      eval_q <= cmd_i.read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hit_acc_q <= 1'b0;
    end else if (eval_q) begin
      hit_acc_q <= hit_acc_q | (|overlap);
    end
    if (cmd_i.publish) hit_q <= hit_acc_q;
  end

  assign hit_o = hit_q;

endmodule

`default_nettype wire

[hw/rtl/sprite_pixel_collision.sv]
// sprite_pixel_collision: top level with register file, controller and datapath
// depends on spc_pkg, spc_item_if, spc_hit_if, spc_cfg_if, spc_ctrl, spc_datapath
`default_nettype none

// Pixel-exact collision test of two sprites held as MAX_DIM x MAX_DIM opaque
// masks, one row word per memory entry. A load item inside its sprite writes
// one mask bit in the cycle it is accepted, so loads stream at one per cycle
// while no check runs. A check runs three steps of rectangle setup, reads one
// overlapping row per cycle, limited by the single read port of each mask
// memory, folds the last row and loads the result register once any earlier
// result is taken; an empty overlap skips scan and fold. The result register
// holds the hit flag until taken while loads go on. Masks have no reset:
// every pixel inside a sprite must be loaded before a check reads it.
// Register writes are always accepted and must only happen while idle.
module sprite_pixel_collision #(
  parameter int unsigned MAX_DIM = 64
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  spc_item_if.sink   item_i,
  spc_hit_if.source  hit_o,
  spc_cfg_if.sink    cfg_i
);

  logic [spc_pkg::SIZE_W-1:0]  width_a_q, height_a_q, width_b_q, height_b_q;
  logic [spc_pkg::COLOR_W-1:0] key_q;
  logic [spc_pkg::SIZE_W-1:0]  wa_eff, ha_eff, wb_eff, hb_eff;
  logic                        cfg_we;
  spc_pkg::spc_cmd_t           cmd;
  spc_pkg::spc_stat_t          stat;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_a_q  <= spc_pkg::SIZE_RST;
      height_a_q <= spc_pkg::SIZE_RST;
      width_b_q  <= spc_pkg::SIZE_RST;
      height_b_q <= spc_pkg::SIZE_RST;
      key_q      <= spc_pkg::KEY_RST;
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        spc_pkg::REG_WIDTH_A:  width_a_q  <= cfg_i.data[spc_pkg::SIZE_W-1:0];
        spc_pkg::REG_HEIGHT_A: height_a_q <= cfg_i.data[spc_pkg::SIZE_W-1:0];
        spc_pkg::REG_WIDTH_B:  width_b_q  <= cfg_i.data[spc_pkg::SIZE_W-1:0];
        spc_pkg::REG_HEIGHT_B: height_b_q <= cfg_i.data[spc_pkg::SIZE_W-1:0];
        spc_pkg::REG_KEY:      key_q      <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // sizes saturate at the mask dimension
  assign wa_eff = (32'(width_a_q) > MAX_DIM)  ? spc_pkg::SIZE_W'(MAX_DIM) : width_a_q;
  assign ha_eff = (32'(height_a_q) > MAX_DIM) ? spc_pkg::SIZE_W'(MAX_DIM) : height_a_q;
  assign wb_eff = (32'(width_b_q) > MAX_DIM)  ? spc_pkg::SIZE_W'(MAX_DIM) : width_b_q;
  assign hb_eff = (32'(height_b_q) > MAX_DIM) ? spc_pkg::SIZE_W'(MAX_DIM) : height_b_q;

  spc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .action_i     (item_i.action),
    .item_ready_o (item_i.ready),
    .hit_ready_i  (hit_o.ready),
    .hit_valid_o  (hit_o.valid),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  spc_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .pixel_x_i     (item_i.pixel_x),
    .pixel_y_i     (item_i.pixel_y),
    .pixel_color_i (item_i.pixel_color),
    .center_ax_i   (item_i.center_ax),
    .center_ay_i   (item_i.center_ay),
    .center_bx_i   (item_i.center_bx),
    .center_by_i   (item_i.center_by),
    .width_a_i     (wa_eff),
    .height_a_i    (ha_eff),
    .width_b_i     (wb_eff),
    .height_b_i    (hb_eff),
    .key_i         (key_q),
    .hit_o         (hit_o.hit)
  );

endmodule

`default_nettype wire

[hw/rtl/spc_port_chk.sv]
// spc_port_chk: port-level assertions of sprite_pixel_collision and its bind
// depends on spc_pkg and sprite_pixel_collision
`default_nettype none

module spc_port_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       item_valid_i,
  input wire logic       item_ready_i,
  input wire logic [1:0] action_i,
  input wire logic       hit_valid_i,
  input wire logic       hit_ready_i,
  input wire logic       hit_i,
  input wire logic       cfg_ready_i
);

  logic item_acc;
  assign item_acc = item_valid_i && item_ready_i;

  // result transaction holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_valid_i && !hit_ready_i |=> hit_valid_i && $stable(hit_i))
    else $error("result dropped or changed while stalled");

  // a check blocks further items while it runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc && (action_i == spc_pkg::ACT_CHECK) |=> !item_ready_i)
    else $error("item accepted during a running check");

  // loads never produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc && (action_i != spc_pkg::ACT_CHECK) && !hit_valid_i |=> !hit_valid_i)
    else $error("result appeared after a load");

  // register port never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("register port not ready");

endmodule

bind sprite_pixel_collision spc_port_chk u_port_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .item_valid_i (item_i.valid),
  .item_ready_i (item_i.ready),
  .action_i     (item_i.action),
  .hit_valid_i  (hit_o.valid),
  .hit_ready_i  (hit_o.ready),
  .hit_i        (hit_o.hit),
  .cfg_ready_i  (cfg_i.ready)
);

`default_nettype wire
